// ===== rtl/core/five_axis_kinematic_transform_defines.svh =====
// Assertion helpers for the kinematic transform
`ifndef FIVE_AXIS_KINEMATIC_TRANSFORM_DEFINES_SVH
`define FIVE_AXIS_KINEMATIC_TRANSFORM_DEFINES_SVH

// Check an implication at every clock edge outside reset
`define FAKT_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// Check that the right side holds at the clock edge after the left side
`define FAKT_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/fakt_pkg.sv =====
`timescale 1ns / 1ps
package fakt_pkg;

   localparam int ANGLE_BITS   = 16;
   localparam int CORDIC_STEPS = 24;
   localparam int ANGLE_W      = 31;   // signed residual angle, 2^-32 turn units
   localparam int TRIG_W       = 33;   // Q2.30 datapath with headroom
   localparam int POS_W        = 32;
   localparam int Q16_W        = 18;
   localparam int SUM_W        = 68;
   localparam int CFG_AW       = 4;
   localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 33'sd652032874;

   typedef enum logic [1:0] {
      MODE_TCP   = 2'd0,
      MODE_TILT  = 2'd1,
      MODE_TABLE = 2'd2,
      MODE_SPARE = 2'd3
   } mode_type;

   typedef enum logic [CFG_AW-1:0] {
      ADDR_MODE   = 4'h0,
      ADDR_LENGTH = 4'h4,
      ADDR_RADIUS = 4'h8
   } addr_type;

   // item payload travelling along the row of cells
   typedef struct packed {
      logic              opcode;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } item_type;

   // one CORDIC lane: residual angle, x, y, quadrant
   typedef struct packed {
      logic signed [ANGLE_W-1:0] z;
      logic signed [TRIG_W-1:0]  x;
      logic signed [TRIG_W-1:0]  y;
      logic [1:0]                quad;
   } lane_type;

   typedef struct packed {
      lane_type lane_b;
      lane_type lane_c;
      item_type item;
   } cell_type;

   function automatic logic signed [ANGLE_W-1:0] atan_turn(input int i);
      logic signed [ANGLE_W-1:0] t;
      begin
         case (i)
            0: t = 31'sd536870912;  1: t = 31'sd316933406;
            2: t = 31'sd167458907;  3: t = 31'sd85004756;
            4: t = 31'sd42667331;   5: t = 31'sd21354465;
            6: t = 31'sd10679838;   7: t = 31'sd5340245;
            8: t = 31'sd2670163;    9: t = 31'sd1335087;
            10: t = 31'sd667544;    11: t = 31'sd333772;
            12: t = 31'sd166886;    13: t = 31'sd83443;
            14: t = 31'sd41722;     15: t = 31'sd20861;
            16: t = 31'sd10430;     17: t = 31'sd5215;
            18: t = 31'sd2608;      19: t = 31'sd1304;
            20: t = 31'sd652;       21: t = 31'sd326;
            22: t = 31'sd163;       default: t = 31'sd81;
         endcase
         return t;
      end
   endfunction

   // one CORDIC rotation; >>> on signed values is the floor shift
   function automatic lane_type rotate(input lane_type a, input int i);
      lane_type r;
      logic signed [TRIG_W-1:0] dx;
      logic signed [TRIG_W-1:0] dy;
      begin
         r  = a;
         dx = a.y >>> i;
         dy = a.x >>> i;
         if (!a.z[ANGLE_W-1]) begin
            r.x = a.x - dx; r.y = a.y + dy; r.z = a.z - atan_turn(i);
         end else begin
            r.x = a.x + dx; r.y = a.y - dy; r.z = a.z + atan_turn(i);
         end
         return r;
      end
   endfunction

   // round Q2.30 to Q1.16 and clamp to one
   function automatic logic signed [Q16_W-1:0] trig_round(input logic signed [TRIG_W-1:0] v);
      logic signed [TRIG_W-1:0] t;
      begin
         t = (v + 33'sd8192) >>> 14;
         if (t > 33'sd65536) t = 33'sd65536;
         else if (t < -33'sd65536) t = -33'sd65536;
         return t[Q16_W-1:0];
      end
   endfunction

endpackage

// ===== rtl/core/fakt_cordic_cell.sv =====
`timescale 1ns / 1ps
module fakt_cordic_cell
   import fakt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic [4:0] step,
   input  logic     valid_in,
   input  cell_type data_in,
   output logic     valid_out,
   output cell_type data_out
);

   logic     valid_ff;
   cell_type data_ff;
   cell_type data_in_w;

   // rotate both lanes by this cell's step
   always_comb begin
      data_in_w        = data_in;
      data_in_w.lane_b = rotate(data_in.lane_b, int'(step));
      data_in_w.lane_c = rotate(data_in.lane_c, int'(step));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in_w;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

// ===== rtl/core/fakt_combine.sv =====
`timescale 1ns / 1ps
module fakt_combine
   import fakt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        valid_in,
   input  cell_type    data_in,
   input  mode_type    mode,
   input  logic [29:0] tool_length,
   input  logic [29:0] table_radius,
   output logic        valid_out,
   output logic [POS_W-1:0] out_x,
   output logic [POS_W-1:0] out_y,
   output logic [POS_W-1:0] out_z,
   output logic [Q16_W-1:0] normal_x,
   output logic [Q16_W-1:0] normal_y,
   output logic [Q16_W-1:0] normal_z,
   output logic        saturated
);

   // stage 1: trig values, quadrant map
   logic        v1_ff;
   item_type    it1_ff;
   logic signed [Q16_W-1:0] sb1_ff, cb1_ff, sc1_ff, cc1_ff;
   logic signed [Q16_W-1:0] sb_in, cb_in, sc_in, cc_in;
   logic signed [Q16_W-1:0] c0, s0;

   always_comb begin
      c0 = trig_round(data_in.lane_b.x);
      s0 = trig_round(data_in.lane_b.y);
      case (data_in.lane_b.quad)
         2'd0: begin cb_in = c0;  sb_in = s0;  end
         2'd1: begin cb_in = -s0; sb_in = c0;  end
         2'd2: begin cb_in = -c0; sb_in = -s0; end
         default: begin cb_in = s0; sb_in = -c0; end
      endcase
      c0 = trig_round(data_in.lane_c.x);
      s0 = trig_round(data_in.lane_c.y);
      case (data_in.lane_c.quad)
         2'd0: begin cc_in = c0;  sc_in = s0;  end
         2'd1: begin cc_in = -s0; sc_in = c0;  end
         2'd2: begin cc_in = -c0; sc_in = -s0; end
         default: begin cc_in = s0; sc_in = -c0; end
      endcase
   end

   // stage 2: trig products
   logic        v2_ff;
   item_type    it2_ff;
   logic signed [Q16_W-1:0] sb2_ff, cb2_ff, sc2_ff, cc2_ff;
   logic signed [Q16_W-1:0] sbsc2_ff, sbcc2_ff, cbsc2_ff, cbcc2_ff;

   function automatic logic signed [Q16_W-1:0] mul_q16(input logic signed [Q16_W-1:0] a,
                                                        input logic signed [Q16_W-1:0] b);
      logic signed [2*Q16_W-1:0] p;
      begin
         p = (a * b + 36'sd32768) >>> 16;
         return p[Q16_W-1:0];
      end
   endfunction

   // stage 3: position products, one per term
   logic        v3_ff;
   logic        inv3_ff;
   mode_type    md3_ff;
   logic signed [Q16_W-1:0] nx3_ff, ny3_ff, nz3_ff;
   logic signed [SUM_W-1:0] t3_ff [0:8];
   logic signed [SUM_W-1:0] t3_in [0:8];
   logic signed [SUM_W-1:0] px, py, pz, lq, rq;

   always_comb begin
      px = SUM_W'(it2_ff.pos_x);
      py = SUM_W'(it2_ff.pos_y);
      pz = SUM_W'(it2_ff.pos_z);
      lq = SUM_W'($signed({1'b0, tool_length}));
      rq = SUM_W'($signed({1'b0, table_radius}));
      for (int k = 0; k < 9; k++) t3_in[k] = '0;
      case (mode)
         MODE_TILT: begin
            t3_in[0] = px <<< 16;
            t3_in[1] = rq * SUM_W'(cc2_ff);
            t3_in[2] = lq * SUM_W'(sbsc2_ff);
            t3_in[3] = rq <<< 16;
            t3_in[4] = py <<< 16;
            t3_in[5] = rq * SUM_W'(sc2_ff);
            t3_in[6] = lq * SUM_W'(sbcc2_ff);
            t3_in[7] = pz <<< 16;
            t3_in[8] = lq * SUM_W'(cb2_ff);
         end
         MODE_TABLE: begin
            if (!it2_ff.opcode) begin
               t3_in[0] = px * SUM_W'(sc2_ff);
               t3_in[1] = py * SUM_W'(cc2_ff);
               t3_in[2] = px * SUM_W'(cbcc2_ff);
               t3_in[3] = -(py * SUM_W'(cbsc2_ff));
               t3_in[4] = pz * SUM_W'(sb2_ff);
               t3_in[5] = -(px * SUM_W'(sbcc2_ff));
               t3_in[6] = py * SUM_W'(sbsc2_ff);
               t3_in[7] = pz * SUM_W'(cb2_ff);
            end else begin
               t3_in[0] = py * SUM_W'(cbcc2_ff);
               t3_in[1] = px * SUM_W'(sc2_ff);
               t3_in[2] = -(pz * SUM_W'(sbcc2_ff));
               t3_in[3] = -(py * SUM_W'(cbsc2_ff));
               t3_in[4] = px * SUM_W'(cc2_ff);
               t3_in[5] = pz * SUM_W'(sbsc2_ff);
               t3_in[6] = -(py * SUM_W'(sb2_ff));
               t3_in[7] = pz * SUM_W'(cb2_ff);
            end
         end
         default: begin
            t3_in[0] = px <<< 16;
            t3_in[4] = py <<< 16;
            t3_in[7] = pz <<< 16;
         end
      endcase
   end

   // stage 4: sums per axis
   logic        v4_ff;
   logic signed [Q16_W-1:0] nx4_ff, ny4_ff, nz4_ff;
   logic signed [SUM_W-1:0] ax4_ff, ay4_ff, az4_ff;
   logic signed [SUM_W-1:0] ax_in, ay_in, az_in, lo;

   always_comb begin
      lo = SUM_W'($signed({1'b0, tool_length})) <<< 16;
      case (md3_ff)
         MODE_TILT: begin
            if (!inv3_ff) begin
               ax_in = t3_ff[0] - t3_ff[1] + t3_ff[2] + t3_ff[3];
               ay_in = t3_ff[4] - t3_ff[5] - t3_ff[6];
               az_in = t3_ff[7] + t3_ff[8] - lo;
            end else begin
               ax_in = t3_ff[0] + t3_ff[1] - t3_ff[2] - t3_ff[3];
               ay_in = t3_ff[4] + t3_ff[5] + t3_ff[6];
               az_in = t3_ff[7] - t3_ff[8] + lo;
            end
         end
         MODE_TABLE: begin
            if (!inv3_ff) begin
               ax_in = t3_ff[0] + t3_ff[1];
               ay_in = t3_ff[2] + t3_ff[3] + t3_ff[4];
               az_in = t3_ff[5] + t3_ff[6] + t3_ff[7];
            end else begin
               ax_in = t3_ff[0] + t3_ff[1] + t3_ff[2];
               ay_in = t3_ff[3] + t3_ff[4] + t3_ff[5];
               az_in = t3_ff[6] + t3_ff[7];
            end
         end
         default: begin
            ax_in = t3_ff[0];
            ay_in = t3_ff[4];
            az_in = t3_ff[7];
         end
      endcase
   end

   // stage 5: round and saturate
   function automatic logic [POS_W:0] finish(input logic signed [SUM_W-1:0] s);
      logic signed [SUM_W-1:0] v;
      begin
         v = (s + SUM_W'(32768)) >>> 16;
         if (v > SUM_W'(64'sh7FFFFFFF)) return {1'b1, 32'h7FFFFFFF};
         if (v < -SUM_W'(64'sh80000000)) return {1'b1, 32'h80000000};
         return {1'b0, v[POS_W-1:0]};
      end
   endfunction

   logic        v5_ff;
   logic [POS_W-1:0] ox_ff, oy_ff, oz_ff;
   logic [Q16_W-1:0] nx5_ff, ny5_ff, nz5_ff;
   logic        sat5_ff;
   logic [POS_W:0] fx, fy, fz;

   always_comb begin
      fx = finish(ax4_ff);
      fy = finish(ay4_ff);
      fz = finish(az4_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0; v5_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= valid_in; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff; v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         it1_ff <= data_in.item;
         sb1_ff <= sb_in; cb1_ff <= cb_in; sc1_ff <= sc_in; cc1_ff <= cc_in;
         it2_ff <= it1_ff;
         sb2_ff <= sb1_ff; cb2_ff <= cb1_ff; sc2_ff <= sc1_ff; cc2_ff <= cc1_ff;
         sbsc2_ff <= mul_q16(sb1_ff, sc1_ff);
         sbcc2_ff <= mul_q16(sb1_ff, cc1_ff);
         cbsc2_ff <= mul_q16(cb1_ff, sc1_ff);
         cbcc2_ff <= mul_q16(cb1_ff, cc1_ff);
         inv3_ff <= it2_ff.opcode;
         md3_ff  <= mode;
         nx3_ff  <= (mode == MODE_TILT) ? sbsc2_ff : -sbsc2_ff;
         ny3_ff  <= -sbcc2_ff;
         nz3_ff  <= cb2_ff;
         for (int k = 0; k < 9; k++) t3_ff[k] <= t3_in[k];
         ax4_ff <= ax_in; ay4_ff <= ay_in; az4_ff <= az_in;
         nx4_ff <= nx3_ff; ny4_ff <= ny3_ff; nz4_ff <= nz3_ff;
         ox_ff <= fx[POS_W-1:0]; oy_ff <= fy[POS_W-1:0]; oz_ff <= fz[POS_W-1:0];
         sat5_ff <= fx[POS_W] | fy[POS_W] | fz[POS_W];
         nx5_ff <= nx4_ff; ny5_ff <= ny4_ff; nz5_ff <= nz4_ff;
      end
   end

   assign valid_out = v5_ff;
   assign out_x = ox_ff; assign out_y = oy_ff; assign out_z = oz_ff;
   assign normal_x = nx5_ff; assign normal_y = ny5_ff; assign normal_z = nz5_ff;
   assign saturated = sat5_ff;

endmodule

// ===== rtl/core/five_axis_kinematic_transform.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Payload
// req_      in         tdata: opcode, pos_x, pos_y, pos_z, angle_b, angle_c
// rsp_      out        tdata: out_x..out_z, normal_x..normal_z, saturated
// csr_      in         APB registers: mode @0x0, tool length @0x4, radius @0x8
// The path runs through one load cell, 24 CORDIC cells and five combine stages.
// One point per cycle is accepted while the output is not stalled; the whole row moves together.
// A stalled result freezes the row; req_tready follows rsp_tready or an empty output.
// Synchronous reset clears the valid bits and the CSR registers.
`include "five_axis_kinematic_transform_defines.svh"
module five_axis_kinematic_transform
   import fakt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [135:0] req_tdata,   // opcode, pos_x, pos_y, pos_z, angle_b, angle_c, pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [151:0] rsp_tdata,  // out_x, out_y, out_z, normal_x, normal_y, normal_z, saturated
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [CFG_AW-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [1:0]  mode_ff;
   logic [29:0] length_ff, radius_ff;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 2'd0; length_ff <= '0; radius_ff <= '0;
      end else if (wr_en) begin
         case (csr_paddr)
            ADDR_MODE:   mode_ff   <= csr_pwdata[1:0];
            ADDR_LENGTH: length_ff <= csr_pwdata[29:0];
            ADDR_RADIUS: radius_ff <= csr_pwdata[29:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr)
         ADDR_MODE:   csr_prdata = {30'd0, mode_ff};
         ADDR_LENGTH: csr_prdata = {2'd0, length_ff};
         ADDR_RADIUS: csr_prdata = {2'd0, radius_ff};
         default:     csr_prdata = '0;
      endcase
   end

   logic advance;
   assign advance    = rsp_tready | ~rsp_tvalid;
   assign req_tready = advance;

   // load cell: unpack and reduce angles to a quarter turn
   cell_type load_in;
   logic [31:0] turns_b, turns_c;
   always_comb begin
      turns_b = {req_tdata[97 +: ANGLE_BITS], {(32-ANGLE_BITS){1'b0}}};
      turns_c = {req_tdata[113 +: ANGLE_BITS], {(32-ANGLE_BITS){1'b0}}};
      load_in.item.opcode = req_tdata[0];
      load_in.item.pos_x  = req_tdata[32:1];
      load_in.item.pos_y  = req_tdata[64:33];
      load_in.item.pos_z  = req_tdata[96:65];
      load_in.lane_b.quad = turns_b[31:30];
      load_in.lane_b.z    = {1'b0, turns_b[29:0]};
      load_in.lane_b.x    = CORDIC_GAIN;
      load_in.lane_b.y    = '0;
      load_in.lane_c.quad = turns_c[31:30];
      load_in.lane_c.z    = {1'b0, turns_c[29:0]};
      load_in.lane_c.x    = CORDIC_GAIN;
      load_in.lane_c.y    = '0;
   end

   logic     cv [0:CORDIC_STEPS];
   cell_type cd [0:CORDIC_STEPS];

   always_ff @(posedge clock) begin
      if (reset) cv[0] <= 1'b0;
      else if (advance) cv[0] <= req_tvalid;
   end
   always_ff @(posedge clock) begin
      if (advance) cd[0] <= load_in;
   end

   // row of CORDIC cells
   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
      fakt_cordic_cell u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .step(5'(g)), .valid_in(cv[g]), .data_in(cd[g]),
         .valid_out(cv[g+1]), .data_out(cd[g+1])
      );
   end

   logic [POS_W-1:0] ox, oy, oz;
   logic [Q16_W-1:0] nx, ny, nz;
   logic sat;

   fakt_combine u_combine (
      .clock(clock), .reset(reset), .advance(advance),
      .valid_in(cv[CORDIC_STEPS]), .data_in(cd[CORDIC_STEPS]),
      .mode(mode_type'(mode_ff)), .tool_length(length_ff), .table_radius(radius_ff),
      .valid_out(rsp_tvalid),
      .out_x(ox), .out_y(oy), .out_z(oz),
      .normal_x(nx), .normal_y(ny), .normal_z(nz), .saturated(sat)
   );

   assign rsp_tdata = {1'b0, sat, nz, ny, nx, oz, oy, ox};

   // checks
   `FAKT_ASSERT_IMPL(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   `FAKT_ASSERT_NEXT(a_csr_mode, clock, reset,
      wr_en && csr_paddr == ADDR_MODE, mode_ff == $past(csr_pwdata[1:0]))
   `FAKT_ASSERT_IMPL(a_norm_range, clock, reset, rsp_tvalid,
      $signed(nz) <= 18'sd65536 && $signed(nz) >= -18'sd65536)

endmodule
